>>> design/mlsd_pkg.sv
// mlsd_pkg: shared types and constants for the masked luma deviation block.
// Used by mlsd_ctrl, mlsd_datapath and masked_luma_stddev_core; no dependencies.
`timescale 1ns / 1ps

package mlsd_pkg;

  // Field and accumulator widths
  localparam int LumaW   = 8;
  localparam int CountW  = 9;
  localparam int SumW    = 16;
  localparam int SqSumW  = 24;
  localparam int StdW    = 16;
  localparam int VarW    = 2;

  // Arithmetic widths of the finishing sequence
  localparam int NumW    = 33;           // n*Q - S*S
  localparam int SsW     = 32;           // S*S
  localparam int DenW    = 17;           // n*d, at most 65536
  localparam int FracW   = 16;           // Q8.8 result needs 2^16 scaling of V
  localparam int DvdW    = NumW + FracW; // dividend width
  localparam int QuoW    = 32;           // quotient stays below 2^31
  localparam int SremW   = 18;           // square root partial remainder

  // Step counts of the iterative units
  localparam int DivSteps  = DvdW;
  localparam int SqrtSteps = QuoW / 2;
  localparam int StepW     = 6;

  // Accumulator capacity
  localparam int AccCapacity = 256;

  // Variant codes
  localparam logic [VarW-1:0] VarPopA   = 2'd0;
  localparam logic [VarW-1:0] VarPopB   = 2'd1;
  localparam logic [VarW-1:0] VarSample = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic acc_en;    // accumulate the accepted sample
    logic snap;      // capture totals and clear accumulators
    logic mul_nq;    // n * sum of squares
    logic mul_ss;    // sum * sum
    logic den_num;   // form numerator and divisor, arm the divider
    logic div_step;  // one restoring division step
    logic sqrt_step; // one square root digit
    logic load_out;  // load the result register
  } mlsd_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } mlsd_status_t;

endpackage

>>> design/mlsd_ctrl.sv
// mlsd_ctrl: sequencer for accumulation and the finishing multiply, divide, sqrt.
// Depends on mlsd_pkg; drives mlsd_datapath through mlsd_cmd_t.
`timescale 1ns / 1ps

module mlsd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  last_sample_i,
  input  logic                  out_stall_i,
  input  mlsd_pkg::mlsd_status_t status_i,
  output mlsd_pkg::mlsd_cmd_t    cmd_o,
  output logic                  in_stall_o,
  output logic                  out_valid_o
);

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL_NQ,
    ST_MUL_SS,
    ST_DEN,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_ACC);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACC: begin
        cmd_o.acc_en = accept;
        cmd_o.snap   = accept && last_sample_i;
        if (accept && last_sample_i) begin
          state_d = ST_MUL_NQ;
        end
      end
      ST_MUL_NQ: begin
        cmd_o.mul_nq = 1'b1;
        state_d      = ST_MUL_SS;
      end
      ST_MUL_SS: begin
        cmd_o.mul_ss = 1'b1;
        state_d      = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.den_num = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd_o.load_out = out_free;
        if (out_free) begin
          state_d = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  // Result valid: set on load, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_ACC);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/mlsd_datapath.sv
// mlsd_datapath: accumulators, multiplies, restoring divider, digit-serial sqrt.
// Depends on mlsd_pkg; commanded by mlsd_ctrl.
`timescale 1ns / 1ps

module mlsd_datapath #(
  parameter int KeptLimit = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mlsd_pkg::mlsd_cmd_t               cmd_i,
  output mlsd_pkg::mlsd_status_t            status_o,
  input  logic                              cfg_we_i,
  input  logic [mlsd_pkg::VarW-1:0]         cfg_wdata_i,
  input  logic [mlsd_pkg::LumaW-1:0]        luma_i,
  input  logic                              is_green_i,
  output logic [mlsd_pkg::StdW-1:0]         std_dev_o,
  output logic [mlsd_pkg::CountW-1:0]       kept_count_o
);

  localparam int CountW = mlsd_pkg::CountW;
  localparam int SumW   = mlsd_pkg::SumW;
  localparam int SqSumW = mlsd_pkg::SqSumW;
  localparam int NumW   = mlsd_pkg::NumW;
  localparam int SsW    = mlsd_pkg::SsW;
  localparam int DenW   = mlsd_pkg::DenW;
  localparam int FracW  = mlsd_pkg::FracW;
  localparam int DvdW   = mlsd_pkg::DvdW;
  localparam int QuoW   = mlsd_pkg::QuoW;
  localparam int SremW  = mlsd_pkg::SremW;
  localparam int StdW   = mlsd_pkg::StdW;
  localparam int StepW  = mlsd_pkg::StepW;

  // Configuration
  logic [mlsd_pkg::VarW-1:0] variant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= mlsd_pkg::VarPopA;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  // Running accumulators
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [SqSumW-1:0] sq_q, sq_d;
  logic              keep;
  logic [2*mlsd_pkg::LumaW-1:0] luma_sq;

  assign luma_sq = luma_i * luma_i;
  assign keep    = !is_green_i && (cnt_q < CountW'(KeptLimit));

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    sq_d  = sq_q;
    if (keep) begin
      cnt_d = cnt_q + CountW'(1);
      sum_d = sum_q + SumW'(luma_i);
      sq_d  = sq_q + SqSumW'(luma_sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.snap) begin
      cnt_q <= '0;
      sum_q <= '0;
      sq_q  <= '0;
    end else if (cmd_i.acc_en) begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      sq_q  <= sq_d;
    end
  end

  // Patch totals captured on the last sample
  logic [CountW-1:0] n_q;
  logic [SumW-1:0]   s_q;
  logic [SqSumW-1:0] qs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      n_q  <= cnt_d;
      s_q  <= sum_d;
      qs_q <= sq_d;
    end
  end

  // Products and divisor
  logic [NumW-1:0]   nq_q;
  logic [SsW-1:0]    ss_q;
  logic [DenW-1:0]   den_q;
  logic [CountW-1:0] dvs;
  logic              sample_var;
  logic              too_few;

  assign sample_var = (variant_q == mlsd_pkg::VarSample);
  assign dvs        = sample_var ? (n_q - CountW'(1)) : n_q;
  assign too_few    = sample_var ? (n_q < CountW'(2)) : (n_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_nq) begin
      nq_q <= NumW'(n_q) * NumW'(qs_q);
    end
    if (cmd_i.mul_ss) begin
      ss_q <= SsW'(s_q) * SsW'(s_q);
    end
    if (cmd_i.den_num) begin
      den_q <= DenW'(n_q) * DenW'(dvs);
    end
  end

  // Restoring divider, one quotient bit per cycle; quotient register then feeds sqrt
  logic [DvdW-1:0]  dvd_q;
  logic [DenW-1:0]  rem_q, rem_d;
  logic [QuoW-1:0]  quo_q;
  logic [DenW:0]    trial;
  logic             ge;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign rem_d = ge ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);

  // Square root, two radicand bits per cycle
  logic [SremW-1:0]  srem_q;
  logic [StdW-1:0]   root_q;
  logic [SremW+1:0]  sv;
  logic [SremW+1:0]  strial;
  logic              sge;

  assign sv     = {srem_q, quo_q[QuoW-1 -: 2]};
  assign strial = (SremW+2)'({root_q, 2'b01});
  assign sge    = (sv >= strial);

  // Step counter shared by both units
  logic [StepW-1:0] step_q;
  logic             step_zero;

  assign step_zero = (step_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.den_num) begin
      dvd_q  <= {nq_q - NumW'(ss_q), FracW'(0)};
      rem_q  <= '0;
      srem_q <= '0;
      root_q <= '0;
      step_q <= StepW'(mlsd_pkg::DivSteps - 1);
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q  <= rem_d;
      quo_q  <= {quo_q[QuoW-2:0], ge};
      step_q <= step_zero ? StepW'(mlsd_pkg::SqrtSteps - 1) : step_q - StepW'(1);
    end else if (cmd_i.sqrt_step) begin
      quo_q  <= {quo_q[QuoW-3:0], 2'b00};
      srem_q <= sge ? SremW'(sv - strial) : SremW'(sv);
      root_q <= {root_q[StdW-2:0], sge};
      step_q <= step_q - StepW'(1);
    end
  end

  assign status_o.div_done  = cmd_i.div_step && step_zero;
  assign status_o.sqrt_done = cmd_i.sqrt_step && step_zero;

  // Result register
  logic [StdW-1:0]   std_q;
  logic [CountW-1:0] kept_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      std_q  <= too_few ? '0 : root_q;
      kept_q <= n_q;
    end
  end

  assign std_dev_o    = std_q;
  assign kept_count_o = kept_q;

endmodule

>>> design/masked_luma_stddev_core.sv
// Masked luma standard deviation: counts the non-green samples of a patch and
// reports their deviation in unsigned Q8.8 together with the kept count.
// The input channel takes one sample per transaction; a transaction with
// last_sample_i high closes the patch and produces one result transaction.
// Non-last samples are accepted one per cycle. After the last sample the
// input stalls while the finishing sequence runs: the two multiplies, the
// divisor, the bit-serial divider and the square root unit, then the load
// of the result register, before the result is valid. The divider and the
// square root unit take most of that sequence.
// If the receiver still holds the previous result, loading waits until it is
// taken; the input stays stalled meanwhile. Results hold steady under stall.
// Reset clears the accumulators, the result valid and the variant register.
// The variant register (0 or 1 population, 2 sample deviation) is written by
// the user through cfg_we_i / cfg_wdata_i while no patch is in progress;
// the block has no check. Depends on mlsd_pkg, mlsd_ctrl and mlsd_datapath.
`timescale 1ns / 1ps

module masked_luma_stddev_core #(
  parameter int GRID_SIDE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mlsd_pkg::VarW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mlsd_pkg::LumaW-1:0]    luma_i,
  input  logic                          is_green_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mlsd_pkg::StdW-1:0]     std_dev_o,
  output logic [mlsd_pkg::CountW-1:0]   kept_count_o
);

  localparam int GridArea  = GRID_SIDE * GRID_SIDE;
  localparam int KeptLimit = (GridArea > mlsd_pkg::AccCapacity) ?
                             mlsd_pkg::AccCapacity : GridArea;

  mlsd_pkg::mlsd_cmd_t    cmd;
  mlsd_pkg::mlsd_status_t status;

  mlsd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o)
  );

  mlsd_datapath #(
    .KeptLimit (KeptLimit)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .luma_i       (luma_i),
    .is_green_i   (is_green_i),
    .std_dev_o    (std_dev_o),
    .kept_count_o (kept_count_o)
  );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for masked_luma_stddev_core. It streams luma patches with
// random gaps and result stalls, predicts each patch deviation and kept count, and
// compares them with the block's results. Depends on mlsd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
  import mlsd_pkg::*;

  localparam int GridSide      = 16;
  localparam int KeptLimit     = (GridSide * GridSide > AccCapacity) ? AccCapacity
                                                                      : GridSide * GridSide;
  localparam int IdlePct       = 13;
  localparam int HoldoffCycles = 400;
  localparam int SettleCycles  = 100;
  localparam int TimeoutNs     = 20_000_000;

  // Unused variant code, behaves as population deviation
  localparam logic [VarW-1:0] VarUnused = 2'd3;

  typedef struct {
    logic [StdW-1:0]   std_dev;
    logic [CountW-1:0] kept_count;
  } patch_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [VarW-1:0]     cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [LumaW-1:0]    luma_i        = '0;
  logic                is_green_i    = 1'b0;
  logic                last_sample_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [StdW-1:0]     std_dev_o;
  logic [CountW-1:0]   kept_count_o;

  // Predictor state
  logic [VarW-1:0]     model_variant = VarPopA;
  logic [CountW-1:0]   model_count   = '0;
  logic [SumW-1:0]     model_sum     = '0;
  logic [SqSumW-1:0]   model_sq_sum  = '0;
  patch_result_t       pending_results[$];

  int                  mismatch_count = 0;
  bit                  quiet_mode     = 1'b0;
  bit                  holdoff_req    = 1'b0;
  int                  holdoff_left   = 0;

  masked_luma_stddev_core #(
    .GRID_SIDE(GridSide)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .luma_i       (luma_i),
    .is_green_i   (is_green_i),
    .last_sample_i(last_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .std_dev_o    (std_dev_o),
    .kept_count_o (kept_count_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #(TimeoutNs);
    $display("Mismatches found");
    $finish;
  end

  // floor(256 * deviation) via exact integers and a truncating square root
  function automatic logic [StdW-1:0] predict_deviation(logic [CountW-1:0] n,
                                                        logic [SumW-1:0] s,
                                                        logic [SqSumW-1:0] q,
                                                        logic sample_div);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    if (sample_div ? (n < 2) : (n == 0)) return '0;
    num = 64'(n) * 64'(q) - 64'(s) * 64'(s);
    den = 64'(n) * (sample_div ? 64'(n) - 64'd1 : 64'(n));
    rem = (num << FracW) / den;
    root = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    if (root > 64'd65535) return '1;
    return root[StdW-1:0];
  endfunction

  // Fold one accepted sample into the predictor; a last sample yields a result
  task automatic absorb_sample(input logic [LumaW-1:0] l, input logic g, input logic last);
    patch_result_t res;
    if (!g && model_count < KeptLimit) begin
      model_count  = model_count + 1'b1;
      model_sum    = model_sum + SumW'(l);
      model_sq_sum = model_sq_sum + SqSumW'(16'(l) * 16'(l));
    end
    if (last) begin
      res.std_dev    = predict_deviation(model_count, model_sum, model_sq_sum,
                                         model_variant == VarSample);
      res.kept_count = model_count;
      pending_results = {pending_results, res};
      model_count  = '0;
      model_sum    = '0;
      model_sq_sum = '0;
    end
  endtask

  // One input transaction, with random gaps ahead of it
  task automatic send_sample(input logic [LumaW-1:0] l, input logic g, input logic last);
    while (!quiet_mode && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    luma_i        <= l;
    is_green_i    <= g;
    last_sample_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_sample(l, g, last);
  endtask

  // Stop offering and wait for every predicted result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Variant write at a patch boundary once the block has gone quiet
  task automatic set_variant(input logic [VarW-1:0] v);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_variant = v;
  endtask

  // Receiver stall: random, long hold-off on request, or none in quiet mode
  always @(posedge clk_i) begin
    if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HoldoffCycles;
    end
    if (holdoff_left > 0) begin
      holdoff_left = holdoff_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet_mode) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IdlePct);
    end
  end

  // Result checker: each result transaction against the oldest prediction
  always @(posedge clk_i) begin : check_results
    patch_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: std_dev %0d kept_count %0d",
                 $time, std_dev_o, kept_count_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (std_dev_o !== want.std_dev) begin
          $display("%0t: std_dev expected %0d actual %0d", $time, want.std_dev, std_dev_o);
          mismatch_count++;
        end
        if (kept_count_o !== want.kept_count) begin
          $display("%0t: kept_count expected %0d actual %0d",
                   $time, want.kept_count, kept_count_o);
          mismatch_count++;
        end
      end
    end
  end

  // Reset value of the variant register, population deviation
  task automatic test_reset_variant();
    send_sample(8'd0, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd128, 1'b0, 1'b1);
  endtask

  // Short patches under population deviation, including one with no kept sample
  task automatic test_short_patches();
    send_sample(8'd77, 1'b1, 1'b1);
    send_sample(8'd200, 1'b0, 1'b1);
    send_sample(8'd0, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b1);
  endtask

  // Sample deviation, including the counts below two
  task automatic test_sample_variant();
    set_variant(VarSample);
    send_sample(8'd90, 1'b0, 1'b1);
    send_sample(8'd255, 1'b1, 1'b1);
    send_sample(8'd0, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b1);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b1);
  endtask

  // Unused code and the second population code, green skipping on the way
  task automatic test_other_variants();
    set_variant(VarUnused);
    send_sample(8'd10, 1'b0, 1'b0);
    send_sample(8'd20, 1'b0, 1'b0);
    send_sample(8'd200, 1'b1, 1'b0);
    send_sample(8'd30, 1'b0, 1'b1);
    set_variant(VarPopB);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd255, 1'b0, 1'b0);
    send_sample(8'd0, 1'b1, 1'b0);
    send_sample(8'd0, 1'b0, 1'b1);
  endtask

  // Patches that reach and exceed the kept-sample limit
  task automatic test_patch_overrun();
    int k;
    for (k = 0; k < KeptLimit + 2; k++)
      send_sample(8'($urandom_range(255)), 1'b0, k == KeptLimit + 1);
    for (k = 0; k < KeptLimit; k++)
      send_sample(8'($urandom_range(1) ? 255 : 0), 1'b0, k == KeptLimit - 1);
  endtask

  // Random patches: mixed lengths, green density, spread and variant changes
  task automatic test_random_patches(input int kept_goal);
    int kept_sent;
    int len;
    int green_pct;
    int base;
    int spread;
    int k;
    logic [LumaW-1:0] l;
    logic g;
    kept_sent = 0;
    while (kept_sent < kept_goal) begin
      if ($urandom_range(7) == 0) set_variant(VarW'($urandom_range(3)));
      case ($urandom_range(9))
        0:       len = 1;
        1:       len = $urandom_range(2, 3);
        default: len = $urandom_range(2, 24);
      endcase
      case ($urandom_range(5))
        0:       green_pct = 100;
        1:       green_pct = 70;
        2, 3:    green_pct = 20;
        default: green_pct = 0;
      endcase
      base   = $urandom_range(255);
      spread = $urandom_range(1) ? 255 : $urandom_range(0, 8);
      for (k = 0; k < len; k++) begin
        l = (spread == 255) ? LumaW'($urandom_range(255))
                            : LumaW'((base + $urandom_range(spread)) % 256);
        g = ($urandom_range(99) < green_pct);
        send_sample(l, g, k == len - 1);
        if (!g) kept_sent++;
      end
    end
  endtask

  // A stretch with no input gaps and no receiver stalls
  task automatic test_no_idle_stretch();
    wait_drained();
    quiet_mode = 1'b1;
    test_random_patches(70);
    wait_drained();
    quiet_mode = 1'b0;
  endtask

  // Receiver holds off while short patches keep coming, so the input stalls
  task automatic test_backpressure();
    int p;
    int k;
    wait_drained();
    holdoff_req = 1'b1;
    for (p = 0; p < 6; p++)
      for (k = 0; k < 3; k++)
        send_sample(8'($urandom_range(255)), 1'b0, k == 2);
  endtask

  // Test sequence
  initial begin : run_tests
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_variant();
    test_short_patches();
    test_sample_variant();
    test_other_variants();
    set_variant(VarPopA);
    test_patch_overrun();
    test_backpressure();
    test_no_idle_stretch();
    test_random_patches(125);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> masked_luma_stddev_core.f
design/mlsd_pkg.sv
design/mlsd_ctrl.sv
design/mlsd_datapath.sv
design/masked_luma_stddev_core.sv
tb/tb_top.sv
